// ===== src/spm_pkg.sv =====
// Shared types, codes and constants of the solid-state relay power modulator.
package spm_pkg;

   // Duty scale and field widths.
   localparam int DUTY_FULL_SCALE = 1000;
   localparam int DUTY_W          = 10;
   localparam int MODE_W          = 3;
   localparam int BURST_W         = 16;
   localparam int HALF_W          = 15;
   localparam int PULSE_W         = 10;
   localparam int LOSS_W          = 12;
   localparam int KIND_W          = 2;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 16;

   // Timebase.
   localparam int US_PER_MS   = 1000;
   localparam int PRESCALE_W  = 10;

   // Burst window limits.
   localparam int BURST_MIN_MS      = 100;
   localparam int BURST_FALLBACK_MS = 1000;
   localparam int BURST_PROD_W      = DUTY_W + BURST_W + 1;

   // Phase firing thresholds, expressed directly on the duty value.
   localparam int PHASE_ON_MIN       = (99 * DUTY_FULL_SCALE + 99) / 100;
   localparam int PHASE_OFF_MAX      = DUTY_FULL_SCALE / 100;
   localparam int PHASE_MIN_DELAY_US = 50;
   // The delay countdown runs in units of 1/DUTY_FULL_SCALE microsecond.
   localparam int PHASE_CNT_W        = DUTY_W + HALF_W;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CROSS = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DUTY  = 2'd2;

   // Operating modes.
   localparam logic [MODE_W-1:0] MODE_BURST = 3'd0;
   localparam logic [MODE_W-1:0] MODE_HALF  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FULL  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PHASE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_OFF   = 3'd4;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_MODE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BURST     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PULSE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MAINSLOSS = 3'd4;

   // Phase sequencer stages.
   localparam logic [1:0] STAGE_IDLE  = 2'd0;
   localparam logic [1:0] STAGE_DELAY = 2'd1;
   localparam logic [1:0] STAGE_PULSE = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [BURST_W-1:0] burst_period_ms;
      logic [HALF_W-1:0]  half_period_us;
      logic [PULSE_W-1:0] pulse_us;
      logic [LOSS_W-1:0]  mains_loss_ms;
   } spm_cfg_type;

   typedef struct packed {
      logic ssr_on;
      logic load_active;
      logic mains_lost;
   } spm_result_type;

endpackage

// ===== src/ssr_power_modulator_core.sv =====
// Top level of the solid-state relay power modulator.
//
// Usage: each request on the req_ channel is one event: a one-microsecond
// tick, a mains zero-crossing or a duty update (req_duty_permille, clamped
// to full scale). Every request produces exactly one response on the rsp_
// channel with the relay drive level, the load status and the mains-loss
// flag as they stand after that event.
// The response is registered: it goes to the output register, or to the
// skid stage while that register holds an untaken response. Throughput is
// one request per cycle while req_ready is high; the state update is a
// single pass through the event logic and one 10x15 multiplier for the
// phase delay and one 10x16 multiplier for the burst on-time.
// The response register is backed by a skid stage, so a request is still
// taken while one response waits; req_ready falls only when both hold a
// response, and rises again as soon as the receiver takes one.
// The csr_ channel is always ready; writing the mode register restarts the
// active strategy. Registers should only be written while the block is idle.
// Reset is synchronous and active high: registers return to their defaults
// (mode off), all timers clear and no response is pending.
module ssr_power_modulator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [spm_pkg::KIND_W-1:0]         req_kind,
   input  logic [spm_pkg::DUTY_W-1:0]         req_duty_permille,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_ssr_on,
   output logic                               rsp_load_active,
   output logic                               rsp_mains_lost,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [spm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [spm_pkg::CSR_DATA_W-1:0]     csr_data
);
   import spm_pkg::*;

   spm_cfg_type    cfg_ff, cfg_in;
   spm_result_type result;
   spm_result_type out_ff, out_in;
   spm_result_type skid_ff, skid_in;
   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   logic           csr_write;
   logic           restart;
   logic           req_take;
   logic           rsp_take;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign restart   = csr_write && (csr_index == REG_MODE);

   // Register file writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_MODE:      cfg_in.mode            = csr_data[MODE_W-1:0];
            REG_BURST:     cfg_in.burst_period_ms = csr_data[BURST_W-1:0];
            REG_HALF:      cfg_in.half_period_us  = csr_data[HALF_W-1:0];
            REG_PULSE:     cfg_in.pulse_us        = csr_data[PULSE_W-1:0];
            REG_MAINSLOSS: cfg_in.mains_loss_ms   = csr_data[LOSS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode            <= MODE_OFF;
         cfg_ff.burst_period_ms <= BURST_W'(1000);
         cfg_ff.half_period_us  <= HALF_W'(10000);
         cfg_ff.pulse_us        <= PULSE_W'(150);
         cfg_ff.mains_loss_ms   <= LOSS_W'(500);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = !skid_valid_ff;
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = out_valid_ff && rsp_ready;

   spm_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .step          (req_take),
      .restart       (restart),
      .kind          (req_kind),
      .duty_permille (req_duty_permille),
      .cfg           (cfg_ff),
      .result        (result)
   );

   // Response register with a skid stage behind it.
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || rsp_take) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_ssr_on      = out_ff.ssr_on;
   assign rsp_load_active = out_ff.load_active;
   assign rsp_mains_lost  = out_ff.mains_lost;

endmodule

// ===== src/spm_engine.sv =====
// Modulator state and the per-request update of relay, status and timers.
module spm_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          restart,
   input  logic [spm_pkg::KIND_W-1:0]    kind,
   input  logic [spm_pkg::DUTY_W-1:0]    duty_permille,
   input  spm_pkg::spm_cfg_type          cfg,
   output spm_pkg::spm_result_type       result
);
   import spm_pkg::*;

   logic [DUTY_W-1:0]      duty_ff, duty_in;
   logic [DUTY_W-1:0]      acc_ff, acc_in;
   logic                   fire_ff, fire_in;
   logic                   parity_ff, parity_in;
   logic [PRESCALE_W-1:0]  pres_ff, pres_in;
   logic [BURST_W-1:0]     elapsed_ff, elapsed_in;
   logic [PHASE_CNT_W-1:0] count_ff, count_in;
   logic [1:0]             stage_ff, stage_in;
   logic [LOSS_W-1:0]      loss_ff, loss_in;
   logic                   relay_ff, relay_in, relay_evt;
   logic                   active_ff, active_in, active_evt;

   logic [LOSS_W-1:0]       loss_limit;
   logic [BURST_W-1:0]      burst_len;
   logic [BURST_W-1:0]      elapsed_inc;
   logic [DUTY_W:0]         acc_sum;
   logic [DUTY_W-1:0]       duty_gap;
   logic [PHASE_CNT_W-1:0]  phase_prod;
   logic [PHASE_CNT_W-1:0]  pulse_load;
   logic [BURST_PROD_W-1:0] burst_lhs;
   logic [BURST_PROD_W-1:0] burst_rhs;
   logic                    burst_on;

   // Effective limits with the fallbacks for out-of-range settings.
   assign loss_limit  = (cfg.mains_loss_ms == '0) ? LOSS_W'(1) : cfg.mains_loss_ms;
   assign burst_len   = (cfg.burst_period_ms < BURST_W'(BURST_MIN_MS)) ?
                        BURST_W'(BURST_FALLBACK_MS) : cfg.burst_period_ms;
   assign elapsed_inc = elapsed_ff + BURST_W'(1);
   assign acc_sum     = {1'b0, acc_ff} + {1'b0, duty_ff};
   assign pulse_load  = (cfg.pulse_us == '0) ? PHASE_CNT_W'(1) : PHASE_CNT_W'(cfg.pulse_us);

   // Phase delay in scaled units: (full scale - duty) * half period.
   assign duty_gap   = DUTY_W'(DUTY_FULL_SCALE) - duty_ff;
   assign phase_prod = PHASE_CNT_W'(duty_gap) * PHASE_CNT_W'(cfg.half_period_us);

   // Event handling for ticks, crossings and duty updates.
   always_comb begin
      duty_in    = duty_ff;
      acc_in     = acc_ff;
      fire_in    = fire_ff;
      parity_in  = parity_ff;
      pres_in    = pres_ff;
      elapsed_in = elapsed_ff;
      count_in   = count_ff;
      stage_in   = stage_ff;
      loss_in    = loss_ff;
      relay_evt  = relay_ff;
      active_evt = active_ff;
      if (restart) begin
         relay_evt  = 1'b0;
         active_evt = 1'b0;
         acc_in     = '0;
         fire_in    = 1'b0;
         elapsed_in = '0;
         stage_in   = STAGE_IDLE;
         count_in   = '0;
         loss_in    = '0;
      end else if (step) begin
         case (kind)
            KIND_TICK: begin
               // Phase sequencer advances by one microsecond.
               if (cfg.mode == MODE_PHASE) begin
                  if (stage_ff == STAGE_DELAY) begin
                     if (count_ff < PHASE_CNT_W'(2 * DUTY_FULL_SCALE)) begin
                        relay_evt = 1'b1;
                        stage_in  = STAGE_PULSE;
                        count_in  = pulse_load;
                     end else begin
                        count_in = count_ff - PHASE_CNT_W'(DUTY_FULL_SCALE);
                     end
                  end else if (stage_ff == STAGE_PULSE) begin
                     count_in = count_ff - PHASE_CNT_W'(1);
                     if (count_ff == PHASE_CNT_W'(1)) begin
                        relay_evt = 1'b0;
                        stage_in  = STAGE_IDLE;
                     end
                  end
               end
               // Millisecond prescaler, burst window and loss window.
               if (pres_ff >= PRESCALE_W'(US_PER_MS - 1)) begin
                  pres_in    = '0;
                  elapsed_in = (elapsed_inc >= burst_len) ? '0 : elapsed_inc;
                  if (loss_ff < loss_limit) begin
                     loss_in = loss_ff + LOSS_W'(1);
                     if (loss_in >= loss_limit && cfg.mode inside {[MODE_HALF:MODE_PHASE]})
                     begin
                        relay_evt  = 1'b0;
                        active_evt = 1'b0;
                        stage_in   = STAGE_IDLE;
                        count_in   = '0;
                     end
                  end
               end else begin
                  pres_in = pres_ff + PRESCALE_W'(1);
               end
            end
            KIND_CROSS: begin
               parity_in = ~parity_ff;
               loss_in   = '0;
               case (cfg.mode)
                  MODE_HALF: begin
                     if (acc_sum >= (DUTY_W + 1)'(DUTY_FULL_SCALE)) begin
                        acc_in    = DUTY_W'(acc_sum - (DUTY_W + 1)'(DUTY_FULL_SCALE));
                        relay_evt = 1'b1;
                     end else begin
                        acc_in    = DUTY_W'(acc_sum);
                        relay_evt = 1'b0;
                     end
                     active_evt = relay_evt;
                  end
                  MODE_FULL: begin
                     // The accumulator steps on every other crossing only.
                     if (parity_in) begin
                        if (acc_sum >= (DUTY_W + 1)'(DUTY_FULL_SCALE)) begin
                           acc_in  = DUTY_W'(acc_sum - (DUTY_W + 1)'(DUTY_FULL_SCALE));
                           fire_in = 1'b1;
                        end else begin
                           acc_in  = DUTY_W'(acc_sum);
                           fire_in = 1'b0;
                        end
                     end
                     relay_evt  = fire_in;
                     active_evt = fire_in;
                  end
                  MODE_PHASE: begin
                     active_evt = (duty_ff > DUTY_W'(PHASE_OFF_MAX));
                     if (duty_ff >= DUTY_W'(PHASE_ON_MIN)) begin
                        relay_evt = 1'b1;
                        stage_in  = STAGE_IDLE;
                     end else if (duty_ff <= DUTY_W'(PHASE_OFF_MAX)) begin
                        relay_evt = 1'b0;
                        stage_in  = STAGE_IDLE;
                     end else if (phase_prod <
                                  PHASE_CNT_W'(PHASE_MIN_DELAY_US * DUTY_FULL_SCALE)) begin
                        relay_evt = 1'b1;
                        stage_in  = STAGE_IDLE;
                     end else begin
                        stage_in = STAGE_DELAY;
                        count_in = phase_prod;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            KIND_DUTY: begin
               duty_in = (duty_permille > DUTY_W'(DUTY_FULL_SCALE)) ?
                         DUTY_W'(DUTY_FULL_SCALE) : duty_permille;
            end
            default: begin
            end
         endcase
      end
   end

   // Burst on-time test: elapsed + 1 <= duty*len/FS, written without a divider.
   assign burst_lhs = BURST_PROD_W'(BURST_PROD_W'(elapsed_in) + BURST_PROD_W'(1)) *
                      BURST_PROD_W'(DUTY_FULL_SCALE);
   assign burst_rhs = BURST_PROD_W'(duty_in) * BURST_PROD_W'(burst_len);
   assign burst_on  = (burst_lhs <= burst_rhs);

   // Mode-wide overrides applied after every request, except while the mode register is written.
   always_comb begin
      relay_in  = relay_evt;
      active_in = active_evt;
      if (step && !restart) begin
         if (cfg.mode == MODE_BURST) begin
            relay_in  = burst_on;
            active_in = burst_on;
         end else if (cfg.mode >= MODE_OFF) begin
            relay_in  = 1'b0;
            active_in = 1'b0;
         end
      end
   end

   assign result.ssr_on      = relay_in;
   assign result.load_active = active_in;
   assign result.mains_lost  = (loss_in >= loss_limit);

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff    <= '0;
         acc_ff     <= '0;
         fire_ff    <= 1'b0;
         parity_ff  <= 1'b0;
         pres_ff    <= '0;
         elapsed_ff <= '0;
         count_ff   <= '0;
         stage_ff   <= STAGE_IDLE;
         loss_ff    <= '0;
         relay_ff   <= 1'b0;
         active_ff  <= 1'b0;
      end else begin
         duty_ff    <= duty_in;
         acc_ff     <= acc_in;
         fire_ff    <= fire_in;
         parity_ff  <= parity_in;
         pres_ff    <= pres_in;
         elapsed_ff <= elapsed_in;
         count_ff   <= count_in;
         stage_ff   <= stage_in;
         loss_ff    <= loss_in;
         relay_ff   <= relay_in;
         active_ff  <= active_in;
      end
   end

endmodule

// ===== src/spm_checker.sv =====
// Port-level checks of the modulator, attached to the top level by bind.
module spm_port_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_ssr_on,
   input logic rsp_load_active,
   input logic rsp_mains_lost
);

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ssr_on) &&
      $stable(rsp_load_active) && $stable(rsp_mains_lost))
      else $error("stalled response changed");

   // After an accepted request, a response is valid in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   // Back-pressure only appears while a response is waiting.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request refused with no response pending");

   // The relay is never driven while the load is reported inactive.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ssr_on |-> rsp_load_active)
      else $error("relay on with load inactive");

   // Reset empties the response path.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

endmodule

bind ssr_power_modulator_core spm_port_checker u_spm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_ssr_on      (rsp_ssr_on),
   .rsp_load_active (rsp_load_active),
   .rsp_mains_lost  (rsp_mains_lost)
);
